>>> rtl/md4_pkg.sv
package md4_pkg;

  localparam logic [31:0] IV_A = 32'h6745_2301;
  localparam logic [31:0] IV_B = 32'hefcd_ab89;
  localparam logic [31:0] IV_C = 32'h98ba_dcfe;
  localparam logic [31:0] IV_D = 32'h1032_5476;

  localparam logic [31:0] K_ROUND1 = 32'h0000_0000;
  localparam logic [31:0] K_ROUND2 = 32'h5A82_7999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9_EBA1;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LAST_STEP   = 6'd47;
  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [6:0] LEN_POS     = 7'd56;
  localparam logic [2:0] WORD_BYTES  = 3'd4;

  localparam logic [1:0] RND_F = 2'd0;
  localparam logic [1:0] RND_G = 2'd1;
  localparam logic [1:0] RND_H = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPRESS,
    S_SPILL,
    S_PAD,
    S_LENBLK,
    S_FINISH
  } state_t;

  // What follows the compression that is running
  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD1,
    PH_FINAL
  } phase_t;

  typedef struct packed {
    logic load_in;
    logic load_spill;
    logic pad;
    logic lenblk;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full_in;
    logic fill_ge56;
    logic last_step;
    logic out_valid;
  } status_t;

  function automatic logic [31:0] round_f(input logic [1:0] rnd, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    logic [31:0] f;
    case (rnd)
      RND_F:   f = z ^ (x & (y ^ z));
      RND_G:   f = (x & y) | (x & z) | (y & z);
      default: f = x ^ y ^ z;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [1:0] rnd);
    logic [31:0] k;
    case (rnd)
      RND_F:   k = K_ROUND1;
      RND_G:   k = K_ROUND2;
      default: k = K_ROUND3;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] msg_index(input logic [1:0] rnd, input logic [3:0] j);
    logic [3:0] idx;
    case (rnd)
      RND_F:   idx = j;
      RND_G:   idx = {j[1:0], j[3:2]};
      default: idx = {j[0], j[1], j[2], j[3]};
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [1:0] rnd, input logic [1:0] j);
    logic [4:0] s;
    case ({rnd, j})
      {RND_F, 2'd0}: s = 5'd3;
      {RND_F, 2'd1}: s = 5'd7;
      {RND_F, 2'd2}: s = 5'd11;
      {RND_F, 2'd3}: s = 5'd19;
      {RND_G, 2'd0}: s = 5'd3;
      {RND_G, 2'd1}: s = 5'd5;
      {RND_G, 2'd2}: s = 5'd9;
      {RND_G, 2'd3}: s = 5'd13;
      {RND_H, 2'd0}: s = 5'd3;
      {RND_H, 2'd1}: s = 5'd9;
      {RND_H, 2'd2}: s = 5'd11;
      default:       s = 5'd15;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    return (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

endpackage

>>> rtl/md4_ctrl.sv
module md4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              last,
  input  logic              out_ready,
  input  md4_pkg::status_t  status,
  output md4_pkg::cmd_t     cmd
);
  import md4_pkg::*;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   last_pend, last_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_DATA;
      last_pend <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      last_pend <= last_pend_next;
    end
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    last_pend_next = last_pend;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        // hold off requests while reset is applied
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load_in    = 1'b1;
          last_pend_next = last;
          if (status.full_in) begin
            phase_next = PH_DATA;
            state_next = S_COMPRESS;
          end else if (last) begin
            state_next = S_PAD;
          end
        end
      end
      S_COMPRESS: begin
        cmd.step = 1'b1;
        if (status.last_step) begin
          unique case (phase)
            PH_DATA:  state_next = S_SPILL;
            PH_PAD1:  state_next = S_LENBLK;
            PH_FINAL: state_next = S_FINISH;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_SPILL: begin
        // place bytes that overran the block just compressed
        cmd.load_spill = 1'b1;
        state_next     = last_pend ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        cmd.pad    = 1'b1;
        phase_next = status.fill_ge56 ? PH_PAD1 : PH_FINAL;
        state_next = S_COMPRESS;
      end
      S_LENBLK: begin
        cmd.lenblk = 1'b1;
        phase_next = PH_FINAL;
        state_next = S_COMPRESS;
      end
      S_FINISH: begin
        // hold until the previous digest is taken
        if (!status.out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.load_spill, cmd.pad, cmd.lenblk, cmd.step, cmd.finish}))
    else $error("more than one datapath command at once");

  a_compress_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPRESS && status.last_step) |=> state != S_COMPRESS)
    else $error("compression did not end after the last step");

  a_full_compress: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_in && status.full_in) |=> state == S_COMPRESS)
    else $error("full block not compressed");
`endif

endmodule

>>> rtl/md4_datapath.sv
module md4_datapath (
  input  logic              clk,
  input  logic              rst,
  input  md4_pkg::cmd_t     cmd,
  output md4_pkg::status_t  status,
  input  logic [31:0]       data_word,
  input  logic [2:0]        byte_count,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [31:0]       digest_a,
  output logic [31:0]       digest_b,
  output logic [31:0]       digest_c,
  output logic [31:0]       digest_d
);
  import md4_pkg::*;

  logic [31:0] blk [16];
  logic [31:0] blk_next [16];
  logic [6:0]  fill;
  logic [60:0] total;
  logic [5:0]  step;
  logic [31:0] ca, cb, cc, cd;
  logic [31:0] ra, rb, rc, rd;
  logic [23:0] spill_data;
  logic [1:0]  spill_cnt;

  logic [2:0]  cnt_in;
  logic [6:0]  room;
  logic [2:0]  n_in;
  logic        wr_en;
  logic [31:0] wr_src;
  logic [2:0]  wr_n;
  logic [31:0] len_lo, len_hi;
  logic        len_wr;

  logic [1:0]  rnd;
  logic [3:0]  j;
  logic [31:0] sum;
  logic [31:0] newv;

  assign cnt_in = (byte_count > WORD_BYTES) ? WORD_BYTES : byte_count;
  assign room   = BLOCK_BYTES - fill;
  assign n_in   = ({4'd0, cnt_in} < room) ? cnt_in : room[2:0];

  assign wr_en  = cmd.load_in || cmd.load_spill;
  assign wr_src = cmd.load_spill ? {8'd0, spill_data} : data_word;
  assign wr_n   = cmd.load_spill ? {1'b0, spill_cnt} : n_in;

  assign len_lo = {total[28:0], 3'b000};
  assign len_hi = total[60:29];
  assign len_wr = (cmd.pad && (fill < LEN_POS)) || cmd.lenblk;

  assign status.full_in   = (fill + {4'd0, n_in}) == BLOCK_BYTES;
  assign status.fill_ge56 = fill >= LEN_POS;
  assign status.last_step = step == LAST_STEP;
  assign status.out_valid = out_valid;

  always_comb begin
    logic [6:0] p;
    logic [6:0] d;
    logic [7:0] nb;
    for (int w = 0; w < 16; w++) begin
      for (int b = 0; b < 4; b++) begin
        p  = 7'(w * 4 + b);
        d  = p - fill;
        nb = blk[w][8*b +: 8];
        if (wr_en && (p >= fill) && (d < {4'd0, wr_n})) begin
          nb = wr_src[{d[1:0], 3'b000} +: 8];
        end
        if (cmd.pad) begin
          if (p == fill) begin
            nb = PAD_BYTE;
          end else if (p > fill) begin
            nb = 8'd0;
          end
        end
        if (cmd.lenblk) begin
          nb = 8'd0;
        end
        blk_next[w][8*b +: 8] = nb;
      end
    end
    if (len_wr) begin
      blk_next[14] = len_lo;
      blk_next[15] = len_hi;
    end
  end

  // one MD4 step per cycle; registers rotate so the target is always ra
  assign rnd  = step[5:4];
  assign j    = step[3:0];
  assign sum  = ra + round_f(rnd, rb, rc, rd) + blk[msg_index(rnd, j)] + round_k(rnd);
  assign newv = rotl32(sum, rot_amount(rnd, j[1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      ca        <= IV_A;
      cb        <= IV_B;
      cc        <= IV_C;
      cd        <= IV_D;
      ra        <= IV_A;
      rb        <= IV_B;
      rc        <= IV_C;
      rd        <= IV_D;
      fill      <= '0;
      total     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        fill  <= fill + {4'd0, n_in};
        total <= total + 61'(cnt_in);
      end
      if (cmd.load_spill) begin
        fill <= {5'd0, spill_cnt};
      end
      if (cmd.step) begin
        if (step == LAST_STEP) begin
          // fold working words into the chaining value
          ca   <= ca + rd;
          cb   <= cb + newv;
          cc   <= cc + rb;
          cd   <= cd + rc;
          ra   <= ca + rd;
          rb   <= cb + newv;
          rc   <= cc + rb;
          rd   <= cd + rc;
          step <= '0;
          fill <= '0;
        end else begin
          ra   <= rd;
          rb   <= newv;
          rc   <= rb;
          rd   <= rc;
          step <= step + 6'd1;
        end
      end
      if (cmd.finish) begin
        ca        <= IV_A;
        cb        <= IV_B;
        cc        <= IV_C;
        cd        <= IV_D;
        ra        <= IV_A;
        rb        <= IV_B;
        rc        <= IV_C;
        rd        <= IV_D;
        fill      <= '0;
        total     <= '0;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < 16; w++) begin
      blk[w] <= blk_next[w];
    end
    if (cmd.load_in) begin
      spill_data <= 24'(data_word >> {n_in, 3'b000});
      spill_cnt  <= 2'(cnt_in - n_in);
    end
    if (cmd.finish) begin
      digest_a <= ca;
      digest_b <= cb;
      digest_c <= cc;
      digest_d <= cd;
    end
  end

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= BLOCK_BYTES)
    else $error("block fill beyond 64 bytes");

  a_finish_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (fill == '0 && total == '0 && step == '0 && out_valid))
    else $error("message state not cleared after digest");

  a_step_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && step == LAST_STEP) |=> (step == '0 && fill == '0))
    else $error("step counter or fill not cleared after compression");
`endif

endmodule

>>> rtl/md4_digest_engine.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   data_word, byte_count, last
// out      output     out_valid / out_ready digest_a, digest_b, digest_c, digest_d
//
// Each request is loaded while idle; each full 64-byte block is then compressed in
// 48 steps (one step per cycle through one adder chain), and the bytes that overran
// it are placed afterwards.
// The last request adds a pad step and a compression (twice over when
// 8 bytes or fewer remain in the block), then the digest is posted.
// Synchronous reset restores the initial chaining words and clears the fill, length and step counts.
// A pending digest does not block new requests; a next digest waits until it is taken.
module md4_digest_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_a,
  output logic [31:0] digest_b,
  output logic [31:0] digest_c,
  output logic [31:0] digest_d
);
  import md4_pkg::*;

  cmd_t    cmd;
  status_t status;

  md4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  md4_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .data_word  (data_word),
    .byte_count (byte_count),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .digest_a   (digest_a),
    .digest_b   (digest_b),
    .digest_c   (digest_c),
    .digest_d   (digest_d)
  );

endmodule

>>> sim/tb_top.sv
module tb_top;
  import md4_pkg::*;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md_digest_t;

  localparam int TOTAL_ITEMS = 950;
  localparam int HOLD_CYCLES = 600;
  // rotation amounts per round, lane 0 in the low bits
  localparam logic [19:0] ROT_F = {5'd19, 5'd11, 5'd7, 5'd3};
  localparam logic [19:0] ROT_G = {5'd13, 5'd9, 5'd5, 5'd3};
  localparam logic [19:0] ROT_H = {5'd15, 5'd11, 5'd9, 5'd3};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  // predictor state
  logic [31:0] md_chain [4];
  logic [31:0] md_block [16];
  logic [5:0]  md_fill;
  logic [60:0] md_total;

  md_digest_t expected_digests [$];
  int mismatches = 0;
  int sent_items = 0;
  int messages_sent = 0;
  int digests_checked = 0;
  int hold_left = 0;
  logic steady = 1'b0;

  md4_digest_engine dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digest_a   (digest_a),
    .digest_b   (digest_b),
    .digest_c   (digest_c),
    .digest_d   (digest_d)
  );

  always #6 clk = ~clk;

  function automatic void md4_restart();
    md_chain[0] = IV_A;
    md_chain[1] = IV_B;
    md_chain[2] = IV_C;
    md_chain[3] = IV_D;
    for (int i = 0; i < 16; i++) md_block[i] = '0;
    md_fill  = '0;
    md_total = '0;
  endfunction

  function automatic void md4_compress();
    logic [31:0] r [4];
    logic [31:0] x, y, z, f, k, sum;
    int t, j, s, wi;
    for (int i = 0; i < 4; i++) r[i] = md_chain[i];
    for (int i = 0; i < 48; i++) begin
      // registers rotate A, D, C, B
      t = (4 - (i % 4)) % 4;
      x = r[(t + 1) % 4];
      y = r[(t + 2) % 4];
      z = r[(t + 3) % 4];
      j = i % 16;
      if (i < 16) begin
        f  = (x & y) | (~x & z);
        wi = j;
        k  = K_ROUND1;
        s  = ROT_F[5 * (j % 4) +: 5];
      end else if (i < 32) begin
        f  = (x & y) | (x & z) | (y & z);
        wi = (j % 4) * 4 + j / 4;
        k  = K_ROUND2;
        s  = ROT_G[5 * (j % 4) +: 5];
      end else begin
        f  = x ^ y ^ z;
        wi = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
        k  = K_ROUND3;
        s  = ROT_H[5 * (j % 4) +: 5];
      end
      sum  = r[t] + f + md_block[wi] + k;
      r[t] = (sum << s) | (sum >> (32 - s));
    end
    for (int i = 0; i < 4; i++) md_chain[i] = md_chain[i] + r[i];
  endfunction

  function automatic void md4_push_byte(input logic [7:0] b);
    md_block[md_fill[5:2]][8 * md_fill[1:0] +: 8] = b;
    md_fill = md_fill + 6'd1;
    if (md_fill == 6'd0) md4_compress();
  endfunction

  function automatic void md4_take_word(input logic [31:0] w, input logic [2:0] n,
                                        input logic fin);
    int cnt;
    logic [63:0] bit_len;
    md_digest_t dg;
    cnt = (n > 3'd4) ? 4 : int'(n);
    for (int i = 0; i < cnt; i++) md4_push_byte(w[8 * i +: 8]);
    md_total = md_total + 61'(cnt);
    if (fin) begin
      bit_len = {md_total, 3'b000};
      md4_push_byte(PAD_BYTE);
      while (md_fill != 6'd56) md4_push_byte(8'h00);
      for (int i = 0; i < 8; i++) md4_push_byte(bit_len[8 * i +: 8]);
      dg.a = md_chain[0];
      dg.b = md_chain[1];
      dg.c = md_chain[2];
      dg.d = md_chain[3];
      expected_digests.push_back(dg);
      md4_restart();
    end
  endfunction

  task automatic send_word(input logic [31:0] w, input logic [2:0] n, input logic fin);
    if (!steady)
      while ($urandom_range(99) < 12) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid   <= 1'b1;
    data_word  <= w;
    byte_count <= n;
    last       <= fin;
    do @(posedge clk); while (!in_ready);
    md4_take_word(w, n, fin);
    sent_items++;
    if (fin) messages_sent++;
  endtask

  task automatic send_random_message();
    int pick, words, tail;
    logic noisy;
    pick = $urandom_range(99);
    tail = $urandom_range(4);
    if (pick < 3) words = $urandom_range(130, 100);
    else if (pick < 18) words = $urandom_range(3, 1);
    else if (pick < 43) words = $urandom_range(17, 13);
    else if (pick < 55) begin
      // length a multiple of 64 unless the counts are noisy, ended by a full word or an empty one
      words = 16 * $urandom_range(2, 1);
      if ($urandom_range(1) == 0) tail = 4;
      else begin
        words++;
        tail = 0;
      end
    end else if (pick < 65) words = $urandom_range(34, 28);
    else words = $urandom_range(40, 1);
    noisy = ($urandom_range(99) < 12);
    for (int i = 1; i < words; i++)
      send_word($urandom, noisy ? 3'($urandom_range(7)) : 3'd4, 1'b0);
    send_word($urandom, noisy ? 3'($urandom_range(7)) : 3'(tail), 1'b1);
  endtask

  task automatic test_tiny_messages();
    send_word(32'h0000_0000, 3'd0, 1'b1);
    // "abc" with junk above the valid bytes
    send_word(32'hA563_6261, 3'd3, 1'b1);
  endtask

  task automatic test_odd_byte_counts();
    send_word(32'hFFFF_FF11, 3'd1, 1'b0);
    send_word(32'h4433_2211, 3'd5, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
    send_word(32'h1234_5678, 3'd2, 1'b0);
    send_word(32'h8765_4321, 3'd6, 1'b0);
    send_word(32'hDEAD_BEEF, 3'd7, 1'b1);
  endtask

  task automatic test_full_block();
    for (int i = 0; i < 16; i++)
      send_word((i % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF, 3'd4, i == 15);
  endtask

  task automatic test_random_messages(input int item_goal);
    while (sent_items < item_goal) send_random_message();
  endtask

  task automatic test_steady_stream(input int item_goal);
    steady = 1'b1;
    test_random_messages(item_goal);
    steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    hold_left = HOLD_CYCLES;
    // keep offering short messages so that the engine stalls behind the held digest
    for (int m = 0; m < 12; m++) begin
      for (int i = $urandom_range(2); i > 0; i--) send_word($urandom, 3'd4, 1'b0);
      send_word($urandom, 3'($urandom_range(4)), 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (steady) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    md_digest_t want;
    if (!rst && out_valid && out_ready) begin
      digests_checked++;
      if (expected_digests.size() == 0) begin
        $error("digest with none expected: %h %h %h %h",
               digest_a, digest_b, digest_c, digest_d);
        mismatches++;
      end else begin
        want = expected_digests.pop_front();
        if (digest_a !== want.a) begin
          $error("digest_a: expected %h, got %h", want.a, digest_a);
          mismatches++;
        end
        if (digest_b !== want.b) begin
          $error("digest_b: expected %h, got %h", want.b, digest_b);
          mismatches++;
        end
        if (digest_c !== want.c) begin
          $error("digest_c: expected %h, got %h", want.c, digest_c);
          mismatches++;
        end
        if (digest_d !== want.d) begin
          $error("digest_d: expected %h, got %h", want.d, digest_d);
          mismatches++;
        end
      end
    end
  end

  initial begin
    md4_restart();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_tiny_messages();
    test_odd_byte_counts();
    test_full_block();
    test_random_messages(350);
    test_steady_stream(600);
    test_output_backpressure();
    test_random_messages(TOTAL_ITEMS);
    in_valid <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("covered %0d requests in %0d messages: byte counts 0-7, short and long",
             sent_items, messages_sent);
    $display("padding in one and two blocks, %0d digests compared, output held %0d cycles",
             digests_checked, HOLD_CYCLES);
    if (mismatches == 0 && expected_digests.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("tb: failure");
    $finish;
  end

endmodule
